/* design/assert_macros.svh */
// Assertion helpers clocked on i_clk and held off while i_rst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`define PFRA_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) else $error(msg);

`define PFRA_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* design/pfra_pkg.sv */
package pfra_pkg;

    localparam logic MODE_ALLOC = 1'b0;
    localparam logic MODE_FREE  = 1'b1;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_BAD_SIZE = 2'd1;
    localparam logic [1:0] ST_FULL     = 2'd2;
    localparam logic [1:0] ST_OVERFLOW = 2'd3;

    typedef enum logic [3:0] {
        S_IDLE,
        S_FMOD,
        S_FPUSH,
        S_CAND,
        S_CRD,
        S_CMOD,
        S_VADDR,
        S_VRD,
        S_FADDR,
        S_FRD,
        S_SHR,
        S_SHW,
        S_DONE
    } t_state;

endpackage

/* design/pfra_ram.sv */
module pfra_ram #(
    parameter int WIDTH = 10,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

/* design/pfra_mod.sv */
module pfra_mod #(
    parameter int W = 11
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_start,
    input  logic [W-1:0] i_a,
    input  logic [W-1:0] i_b,
    output logic         o_done,
    output logic [W-1:0] o_rem
);

    localparam int CNTW = $clog2(W + 1);

    logic [W-1:0]    r_a, r_b, r_rem;
    logic [CNTW-1:0] r_cnt;
    logic            r_busy, r_done;
    logic [W:0]      trial;

    assign trial = {r_rem, r_a[W-1]};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_done <= 1'b0;
        end else begin
            r_done <= r_busy && (r_cnt == CNTW'(1));
            if (r_busy && (r_cnt == CNTW'(1))) begin
                r_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_a   <= i_a;
            r_b   <= i_b;
            r_rem <= '0;
            r_cnt <= CNTW'(W);
        end else if (r_busy) begin
            r_a   <= {r_a[W-2:0], 1'b0};
            r_cnt <= r_cnt - CNTW'(1);
            if (trial >= {1'b0, r_b}) begin
                r_rem <= W'(trial - {1'b0, r_b});
            end else begin
                r_rem <= trial[W-1:0];
            end
        end
    end

    assign o_done = r_done;
    assign o_rem  = r_rem;

endmodule

/* design/page_frame_run_allocator_core.sv */
// A free reduces start_frame below NUM_FRAMES, then pushes page_count frames from there on;
// a refused or an empty item goes straight to the result.
// An allocate walks the frame list from the top; a fitting candidate costs a remainder pass,
// an aligned one a list scan too, and each removed frame a search and a shift of those above.
// One item is in work at a time; the output register lets the next item be taken early.
// Reset (synchronous, active low) empties the list; the list memory itself is not cleared.
module page_frame_run_allocator_core #(
    parameter int NUM_FRAMES = 1024,
    parameter int MAX_RUN    = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [31:0] i_s_axis_tdata,  // start_frame[9:0], page_count[14:10], align_frames[24:15]
    input  logic        i_s_axis_tuser,  // mode[0]
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [15:0] o_m_axis_tdata,  // base_frame[9:0]
    output logic [1:0]  o_m_axis_tuser   // status[1:0]
);

    `include "assert_macros.svh"

    localparam int AW  = $clog2(NUM_FRAMES);
    localparam int FW  = AW;
    localparam int CW  = $clog2(NUM_FRAMES + 1);
    localparam int W   = (CW > 10) ? CW : 10;
    localparam int IW  = (MAX_RUN > 1) ? $clog2(MAX_RUN) : 1;
    localparam int MRW = 1 << IW;

    pfra_pkg::t_state r_state, n_state;
    logic [CW-1:0]  r_count, n_count, r_k, n_k, r_j, n_j;
    logic [4:0]     r_n, n_n, r_i, n_i;
    logic [9:0]     r_align, n_align;
    logic [FW-1:0]  r_c, n_c, r_f, n_f;
    logic [AW-1:0]  r_p, n_p;
    logic [W-1:0]   r_base, n_base;
    logic [MRW-1:0] r_mask, n_mask;
    logic [1:0]     r_status, n_status;
    logic           r_ovalid, n_ovalid;
    logic [1:0]     r_ostatus, n_ostatus;
    logic [9:0]     r_obase, n_obase;

    logic          ram_we;
    logic [AW-1:0] ram_waddr, ram_raddr;
    logic [FW-1:0] ram_wdata, ram_rdata;
    logic          mod_start, mod_done;
    logic [W-1:0]  mod_a, mod_b, mod_rem;

    logic          accept;
    logic [9:0]    in_start, in_align;
    logic [4:0]    in_n;
    logic [W-1:0]  cw, tw, dw;
    logic          run_ok;
    logic          out_err, push_or_shift;

    pfra_ram #(.WIDTH(FW), .DEPTH(NUM_FRAMES)) u_ram (
        .i_clk  (i_clk),
        .i_we   (ram_we),
        .i_waddr(ram_waddr),
        .i_wdata(ram_wdata),
        .i_raddr(ram_raddr),
        .o_rdata(ram_rdata)
    );

    pfra_mod #(.W(W)) u_mod (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_start(mod_start),
        .i_a    (mod_a),
        .i_b    (mod_b),
        .o_done (mod_done),
        .o_rem  (mod_rem)
    );

    assign o_s_axis_tready = (r_state == pfra_pkg::S_IDLE);
    assign accept          = i_s_axis_tvalid && o_s_axis_tready;
    assign in_start        = i_s_axis_tdata[9:0];
    assign in_n            = i_s_axis_tdata[14:10];
    assign in_align        = i_s_axis_tdata[24:15];

    assign o_m_axis_tvalid = r_ovalid;
    assign o_m_axis_tdata  = {6'd0, r_obase};
    assign o_m_axis_tuser  = r_ostatus;

    assign cw = W'(ram_rdata);
    assign tw = W'(r_c) - W'(r_i);
    assign dw = W'(r_c) - W'(ram_rdata);

    always_comb begin
        run_ok = 1'b1;
        for (int b = 0; b < MRW; b++) begin
            if ((b < int'(r_n)) && !r_mask[b]) begin
                run_ok = 1'b0;
            end
        end
    end

    always_comb begin
        n_state   = r_state;
        n_count   = r_count;
        n_k       = r_k;
        n_j       = r_j;
        n_n       = r_n;
        n_i       = r_i;
        n_align   = r_align;
        n_c       = r_c;
        n_f       = r_f;
        n_p       = r_p;
        n_base    = r_base;
        n_mask    = r_mask;
        n_status  = r_status;
        n_ovalid  = r_ovalid && !i_m_axis_tready;
        n_ostatus = r_ostatus;
        n_obase   = r_obase;
        ram_we    = 1'b0;
        ram_waddr = r_p;
        ram_wdata = ram_rdata;
        ram_raddr = '0;
        mod_start = 1'b0;
        mod_a     = '0;
        mod_b     = '0;

        case (r_state)
            pfra_pkg::S_IDLE: begin
                if (accept) begin
                    n_n     = in_n;
                    n_align = in_align;
                    n_base  = '0;
                    n_i     = '0;
                    n_k     = r_count;
                    if (i_s_axis_tuser == pfra_pkg::MODE_FREE) begin
                        if ((CW + 1)'(r_count) + (CW + 1)'(in_n) > (CW + 1)'(NUM_FRAMES)) begin
                            n_status = pfra_pkg::ST_OVERFLOW;
                            n_state  = pfra_pkg::S_DONE;
                        end else if (in_n == 5'd0) begin
                            n_status = pfra_pkg::ST_OK;
                            n_state  = pfra_pkg::S_DONE;
                        end else begin
                            n_base  = W'(in_start);
                            n_state = pfra_pkg::S_FMOD;
                        end
                    end else if ((in_n == 5'd0) || (32'(in_n) > 32'(MAX_RUN))) begin
                        n_status = pfra_pkg::ST_BAD_SIZE;
                        n_state  = pfra_pkg::S_DONE;
                    end else begin
                        n_state = pfra_pkg::S_CAND;
                    end
                end
            end
            pfra_pkg::S_FMOD: begin
                if (r_base >= W'(NUM_FRAMES)) begin
                    n_base = r_base - W'(NUM_FRAMES);
                end else begin
                    n_f     = r_base[FW-1:0];
                    n_base  = '0;
                    n_state = pfra_pkg::S_FPUSH;
                end
            end
            pfra_pkg::S_FPUSH: begin
                ram_we    = 1'b1;
                ram_waddr = r_count[AW-1:0];
                ram_wdata = r_f;
                n_count   = r_count + CW'(1);
                n_f       = (W'(r_f) + W'(1) == W'(NUM_FRAMES)) ? '0 : r_f + FW'(1);
                n_i       = r_i + 5'd1;
                if (r_i + 5'd1 == r_n) begin
                    n_status = pfra_pkg::ST_OK;
                    n_state  = pfra_pkg::S_DONE;
                end
            end
            pfra_pkg::S_CAND: begin
                if (r_k == '0) begin
                    n_status = pfra_pkg::ST_FULL;
                    n_base   = '0;
                    n_state  = pfra_pkg::S_DONE;
                end else begin
                    ram_raddr = AW'(r_k - CW'(1));
                    n_k       = r_k - CW'(1);
                    n_state   = pfra_pkg::S_CRD;
                end
            end
            pfra_pkg::S_CRD: begin
                n_c = ram_rdata;
                if (cw + W'(1) < W'(r_n)) begin
                    n_state = pfra_pkg::S_CAND;
                end else begin
                    n_base    = cw + W'(1) - W'(r_n);
                    mod_start = 1'b1;
                    mod_a     = cw + W'(1) - W'(r_n);
                    mod_b     = (r_align == 10'd0) ? W'(1) : W'(r_align);
                    n_state   = pfra_pkg::S_CMOD;
                end
            end
            pfra_pkg::S_CMOD: begin
                if (mod_done) begin
                    if (mod_rem == '0) begin
                        n_mask  = '0;
                        n_j     = r_count;
                        n_state = pfra_pkg::S_VADDR;
                    end else begin
                        n_state = pfra_pkg::S_CAND;
                    end
                end
            end
            pfra_pkg::S_VADDR: begin
                if (r_j == '0) begin
                    if (run_ok) begin
                        n_i     = '0;
                        n_j     = r_count;
                        n_state = pfra_pkg::S_FADDR;
                    end else begin
                        n_state = pfra_pkg::S_CAND;
                    end
                end else begin
                    ram_raddr = AW'(r_j - CW'(1));
                    n_j       = r_j - CW'(1);
                    n_state   = pfra_pkg::S_VRD;
                end
            end
            pfra_pkg::S_VRD: begin
                if ((r_c >= ram_rdata) && (dw < W'(r_n))) begin
                    n_mask[dw[IW-1:0]] = 1'b1;
                end
                n_state = pfra_pkg::S_VADDR;
            end
            pfra_pkg::S_FADDR: begin
                ram_raddr = AW'(r_j - CW'(1));
                n_j       = r_j - CW'(1);
                n_state   = pfra_pkg::S_FRD;
            end
            pfra_pkg::S_FRD: begin
                if (cw == tw) begin
                    n_p     = r_j[AW-1:0];
                    n_state = pfra_pkg::S_SHR;
                end else begin
                    n_state = pfra_pkg::S_FADDR;
                end
            end
            pfra_pkg::S_SHR: begin
                if (CW'(r_p) + CW'(1) >= r_count) begin
                    n_count = r_count - CW'(1);
                    n_j     = r_count - CW'(1);
                    n_i     = r_i + 5'd1;
                    if (r_i + 5'd1 == r_n) begin
                        n_status = pfra_pkg::ST_OK;
                        n_state  = pfra_pkg::S_DONE;
                    end else begin
                        n_state = pfra_pkg::S_FADDR;
                    end
                end else begin
                    ram_raddr = AW'(CW'(r_p) + CW'(1));
                    n_state   = pfra_pkg::S_SHW;
                end
            end
            pfra_pkg::S_SHW: begin
                ram_we    = 1'b1;
                ram_waddr = r_p;
                ram_wdata = ram_rdata;
                n_p       = AW'(CW'(r_p) + CW'(1));
                n_state   = pfra_pkg::S_SHR;
            end
            pfra_pkg::S_DONE: begin
                if (!r_ovalid || i_m_axis_tready) begin
                    n_ovalid  = 1'b1;
                    n_ostatus = r_status;
                    n_obase   = (r_status == pfra_pkg::ST_OK) ? r_base[9:0] : 10'd0;
                    n_state   = pfra_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = pfra_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= pfra_pkg::S_IDLE;
            r_count  <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_count  <= n_count;
            r_ovalid <= n_ovalid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_k       <= n_k;
        r_j       <= n_j;
        r_n       <= n_n;
        r_i       <= n_i;
        r_align   <= n_align;
        r_c       <= n_c;
        r_f       <= n_f;
        r_p       <= n_p;
        r_base    <= n_base;
        r_mask    <= n_mask;
        r_status  <= n_status;
        r_ostatus <= n_ostatus;
        r_obase   <= n_obase;
    end

    assign out_err       = o_m_axis_tvalid && (o_m_axis_tuser != pfra_pkg::ST_OK);
    assign push_or_shift = (r_state == pfra_pkg::S_FPUSH) || (r_state == pfra_pkg::S_SHW);

    `PFRA_ASSERT(a_count_range, r_count <= CW'(NUM_FRAMES), "free list count beyond capacity")
    `PFRA_ASSERT(a_err_base_zero, !out_err || (o_m_axis_tdata == 16'd0), "error item has a base")
    `PFRA_ASSERT(a_write_states, !ram_we || push_or_shift, "list written outside push or shift")
    `PFRA_ASSERT_NEXT(a_accept_busy, accept, r_state != pfra_pkg::S_IDLE, "accepted item, idle")

endmodule
